>>> hdl/tac_pkg.sv
package tac_pkg;

    localparam int GAIN_W     = 16;
    localparam int THR_W      = 31;
    localparam int CFG_W      = 31;
    localparam int SCALED_W   = 32;
    localparam int AMP_W      = 34;
    localparam int DUR_W      = 24;
    localparam int COUNT_W    = 25;
    localparam int OUT_W      = 88;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic CFG_SCALE_GAIN     = 1'b0;
    localparam logic CFG_TURN_THRESHOLD = 1'b1;

    localparam logic [GAIN_W-1:0]         GAIN_RESET = 16'd256;
    localparam logic [THR_W-1:0]          THR_RESET  = 31'd25600;
    localparam logic signed [COUNT_W-1:0] COUNT_INIT = -25'sd1;
    localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 25'sd16777215;

    typedef struct packed {
        logic                       last;
        logic signed [SCALED_W-1:0] scaled;
    } tac_item_t;

endpackage

>>> hdl/tac_front.sv
module tac_front
    import tac_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          valid,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    input  logic [GAIN_W-1:0]             gain,
    input  logic                          fifo_full,
    output logic                          ready,
    output logic                          push,
    output tac_item_t                     item
);

    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam int WIDE_W = (PROD_W > SCALED_W + 1) ? PROD_W : SCALED_W + 1;
    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(64'sd2147483647);
    localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(-64'sd2147483648);

    logic signed [PROD_W-1:0] prod;
    logic signed [WIDE_W-1:0] prod_wide;

    assign prod      = PROD_W'(sample) * $signed({1'b0, gain});
    assign prod_wide = WIDE_W'(prod);
    assign ready     = !fifo_full;
    assign push      = valid && ready;

    always_comb
    begin
        item.last = last;
        if (prod_wide > SAT_HI)
        begin
            item.scaled = SAT_HI[SCALED_W-1:0];
        end
        else if (prod_wide < SAT_LO)
        begin
            item.scaled = SAT_LO[SCALED_W-1:0];
        end
        else
        begin
            item.scaled = prod_wide[SCALED_W-1:0];
        end
    end

endmodule

>>> hdl/tac_fifo.sv
module tac_fifo
    import tac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tac_item_t wr_item,
    input  logic      pop,
    output tac_item_t rd_item,
    output logic      not_empty,
    output logic      full
);

    tac_item_t             mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_item   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("item pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> hdl/tac_back.sv
module tac_back
    import tac_pkg::*;
#(
    parameter int INDEX_BITS = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tac_item_t        item,
    input  logic             item_valid,
    input  logic [THR_W-1:0] threshold,
    output logic             pop,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int EXT_W = (INDEX_BITS > DUR_W) ? INDEX_BITS : DUR_W;

    logic                        fresh_reg, fresh_next;
    logic signed [SCALED_W-1:0]  upper_reg, upper_next;
    logic signed [SCALED_W-1:0]  lower_reg, lower_next;
    logic                        rise_arm_reg, rise_arm_next;
    logic                        fall_arm_reg, fall_arm_next;
    logic [INDEX_BITS-1:0]       rise_pos_reg, rise_pos_next;
    logic [INDEX_BITS-1:0]       fall_pos_reg, fall_pos_next;
    logic [INDEX_BITS-1:0]       index_reg, index_next;
    logic signed [COUNT_W-1:0]   count_reg, count_next;
    logic [INDEX_BITS-1:0]       prev_idx_reg, prev_idx_next;
    logic signed [SCALED_W-1:0]  prev_val_reg, prev_val_next;

    logic                        out_valid_reg;
    logic                        found_reg, found_next;
    logic                        polarity_reg, polarity_next;
    logic signed [AMP_W-1:0]     amp_reg, amp_next;
    logic [DUR_W-1:0]            dur_reg, dur_next;
    logic signed [COUNT_W-1:0]   out_count_reg;

    logic signed [SCALED_W-1:0]  cur, up_eff, lo_eff, up1, lo1, prv_val;
    logic [INDEX_BITS-1:0]       idx, rp_eff, fp_eff, rp1, fp1, prv_idx;
    logic [INDEX_BITS-1:0]       idx_diff;
    logic [EXT_W-1:0]            diff_ext;
    logic                        ra_eff, fa_eff, ra1, fa1;
    logic                        rise_hit, fall_hit, positive;
    logic signed [SCALED_W:0]    rise_diff, fall_diff, amp_diff, thr_s;
    logic signed [COUNT_W-1:0]   cnt_eff;

    assign pop      = item_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, dur_reg, amp_reg, polarity_reg, found_reg};

    always_comb
    begin
        cur = item.scaled;
        // a fresh buffer starts from the current sample
        up_eff  = fresh_reg ? cur : upper_reg;
        lo_eff  = fresh_reg ? cur : lower_reg;
        ra_eff  = fresh_reg ? 1'b0 : rise_arm_reg;
        fa_eff  = fresh_reg ? 1'b0 : fall_arm_reg;
        rp_eff  = fresh_reg ? '0 : rise_pos_reg;
        fp_eff  = fresh_reg ? '0 : fall_pos_reg;
        idx     = fresh_reg ? '0 : index_reg;
        cnt_eff = fresh_reg ? COUNT_INIT : count_reg;
        prv_idx = fresh_reg ? '0 : prev_idx_reg;
        prv_val = fresh_reg ? '0 : prev_val_reg;

        thr_s     = $signed({2'b00, threshold});
        rise_diff = {cur[SCALED_W-1], cur} - {lo_eff[SCALED_W-1], lo_eff};
        fall_diff = {up_eff[SCALED_W-1], up_eff} - {cur[SCALED_W-1], cur};
        rise_hit  = rise_diff > thr_s;
        fall_hit  = fall_diff > thr_s;

        ra1 = ra_eff || rise_hit;
        lo1 = rise_hit ? cur : lo_eff;
        rp1 = rise_hit ? idx : rp_eff;
        fa1 = fa_eff || fall_hit;
        up1 = fall_hit ? cur : up_eff;
        fp1 = fall_hit ? idx : fp_eff;

        found_next = ra1 && fa1 && (fp1 != rp1);
        positive   = fp1 > rp1;
        amp_diff   = {cur[SCALED_W-1], cur} - {prv_val[SCALED_W-1], prv_val};
        idx_diff   = idx - prv_idx;
        diff_ext   = EXT_W'(idx_diff);

        polarity_next = found_next && positive;
        amp_next      = found_next ? AMP_W'(amp_diff) : '0;
        dur_next      = found_next ? diff_ext[DUR_W-1:0] : '0;

        count_next    = cnt_eff;
        prev_idx_next = prv_idx;
        prev_val_next = prv_val;
        rise_arm_next = ra1;
        fall_arm_next = fa1;
        if (found_next)
        begin
            if (cnt_eff < COUNT_MAX)
            begin
                count_next = cnt_eff + 1'b1;
            end
            prev_idx_next = idx;
            prev_val_next = cur;
            if (positive)
            begin
                rise_arm_next = 1'b0;
            end
            else
            begin
                fall_arm_next = 1'b0;
            end
        end

        // new extremes move the reference and the opposite position
        upper_next    = up1;
        rise_pos_next = rp1;
        if (cur > up1)
        begin
            upper_next    = cur;
            rise_pos_next = idx;
        end
        lower_next    = lo1;
        fall_pos_next = fp1;
        if (cur < lo1)
        begin
            lower_next    = cur;
            fall_pos_next = idx;
        end

        fresh_next = item.last;
        index_next = idx;
        if (!item.last && (idx != '1))
        begin
            index_next = idx + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg    <= 1'b1;
            upper_reg    <= '0;
            lower_reg    <= '0;
            rise_arm_reg <= 1'b0;
            fall_arm_reg <= 1'b0;
            rise_pos_reg <= '0;
            fall_pos_reg <= '0;
            index_reg    <= '0;
            count_reg    <= COUNT_INIT;
            prev_idx_reg <= '0;
            prev_val_reg <= '0;
        end
        else if (pop)
        begin
            fresh_reg    <= fresh_next;
            upper_reg    <= upper_next;
            lower_reg    <= lower_next;
            rise_arm_reg <= rise_arm_next;
            fall_arm_reg <= fall_arm_next;
            rise_pos_reg <= rise_pos_next;
            fall_pos_reg <= fall_pos_next;
            index_reg    <= index_next;
            count_reg    <= count_next;
            prev_idx_reg <= prev_idx_next;
            prev_val_reg <= prev_val_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            found_reg     <= found_next;
            polarity_reg  <= polarity_next;
            amp_reg       <= amp_next;
            dur_reg       <= dur_next;
            out_count_reg <= count_next;
        end
    end

    a_quiet_no_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |->
            (!polarity_reg && amp_reg == '0 && dur_reg == '0))
        else $error("turn fields set without a turn");

    a_count_floor: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= COUNT_INIT)
        else $error("running count below start value");

    a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.last) |=> fresh_reg)
        else $error("last item did not re-arm buffer start");

endmodule

>>> hdl/turn_amplitude_counter_top.sv
// Amplitude turn counter. Each sample on s_tdata is scaled by the Q8.8 gain and
// produces exactly one result item on m_tdata. The block takes one item per
// clock cycle while the queue is not full: the front end scales the sample in the
// accepting cycle and places it in a four-deep queue; the back end updates the
// reference, arming and count state from one queued item per cycle while the output
// is not stalled, so that the state update sets the rate. A result is offered on
// m_tvalid from the output register after its sample has passed through the queue.
// s_tlast closes a buffer; the next sample restarts tracking and the count
// (from -1). Configuration writes are to be made only while the block is idle.
module turn_amplitude_counter_top
    import tac_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 24
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample, zero-padded to whole bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    // last_sample
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // turn_found, turn_polarity, turn_amplitude, turn_duration, turn_count, pad
    output logic [OUT_W-1:0]                    m_tdata,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [CFG_W-1:0]                    cfg_wdata
);

    logic [GAIN_W-1:0] gain_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              fifo_full;
    logic              fifo_not_empty;
    logic              push;
    logic              pop;
    tac_item_t         wr_item;
    tac_item_t         rd_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            thr_reg  <= THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCALE_GAIN:     gain_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_TURN_THRESHOLD: thr_reg  <= cfg_wdata[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    tac_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .valid     (s_tvalid),
        .sample    ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .last      (s_tlast),
        .gain      (gain_reg),
        .fifo_full (fifo_full),
        .ready     (s_tready),
        .push      (push),
        .item      (wr_item)
    );

    tac_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_item   (wr_item),
        .pop       (pop),
        .rd_item   (rd_item),
        .not_empty (fifo_not_empty),
        .full      (fifo_full)
    );

    tac_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (rd_item),
        .item_valid (fifo_not_empty),
        .threshold  (thr_reg),
        .pop        (pop),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule
